[rtl/att_pkg.sv]
// Shared constants, types and the arctangent table of the tilt-angle block.
// Used by att_cordic_cell, att_cordic_pass, accel_tilt_angles and att_checker.
package att_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int FRAC_W        = 16;
  localparam int VEC_W         = 36;
  localparam int ANG_W         = 26;
  localparam int SIDE_W        = ANG_W;
  localparam int SHIFT_W       = $clog2(CORDIC_STAGES);
  localparam int PITCH_W       = 15;
  localparam int ROLL_W        = 16;
  localparam int THR_W         = 15;
  localparam int ADDR_W        = 2;
  localparam int DATA_W        = 32;

  localparam logic signed [17:0]      GAIN_Q16    = 18'sd107922;
  localparam logic signed [ANG_W-1:0] DEG90_Q16   = ANG_W'(90 * 65536);
  localparam logic [THR_W-1:0]        THR_RESET   = THR_W'(3000);
  localparam logic [THR_W-1:0]        PITCH_LIMIT = THR_W'(9000);
  localparam logic [THR_W-1:0]        ROLL_LIMIT  = THR_W'(18000);

  localparam logic [ADDR_W-1:0] ADDR_MOTION_THRESHOLD = ADDR_W'(0);

  typedef struct packed {
    logic                      zero;
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [ANG_W-1:0]   ang;
    logic        [SIDE_W-1:0]  side;
  } vec_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = ANG_W'(2949120);
      1:       v = ANG_W'(1740967);
      2:       v = ANG_W'(919879);
      3:       v = ANG_W'(466945);
      4:       v = ANG_W'(234379);
      5:       v = ANG_W'(117304);
      6:       v = ANG_W'(58666);
      7:       v = ANG_W'(29335);
      8:       v = ANG_W'(14668);
      9:       v = ANG_W'(7334);
      10:      v = ANG_W'(3667);
      11:      v = ANG_W'(1833);
      12:      v = ANG_W'(917);
      13:      v = ANG_W'(458);
      14:      v = ANG_W'(229);
      15:      v = ANG_W'(115);
      16:      v = ANG_W'(57);
      17:      v = ANG_W'(29);
      18:      v = ANG_W'(14);
      19:      v = ANG_W'(7);
      20:      v = ANG_W'(4);
      21:      v = ANG_W'(2);
      22:      v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/att_cordic_cell.sv]
// One registered vectoring CORDIC iteration: shift-add on the vector and
// angle accumulation. Depends on att_pkg for vec_t and the widths.
module att_cordic_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [att_pkg::SHIFT_W-1:0]       shift_i,
  input  logic signed [att_pkg::ANG_W-1:0]  atan_i,
  input  logic                              v_i,
  input  att_pkg::vec_t                     d_i,
  output logic                              v_o,
  output att_pkg::vec_t                     q_o
);

  logic                 v_r;
  att_pkg::vec_t        q_r;
  att_pkg::vec_t        q_nxt;
  logic signed [att_pkg::VEC_W-1:0] xs;
  logic signed [att_pkg::VEC_W-1:0] ys;

  always_comb begin
    xs    = d_i.x >>> shift_i;
    ys    = d_i.y >>> shift_i;
    q_nxt = d_i;
    if (d_i.y >= 0) begin
      q_nxt.x   = d_i.x + ys;
      q_nxt.y   = d_i.y - xs;
      q_nxt.ang = d_i.ang + atan_i;
    end else begin
      q_nxt.x   = d_i.x - ys;
      q_nxt.y   = d_i.y + xs;
      q_nxt.ang = d_i.ang - atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign v_o = v_r;
  assign q_o = q_r;

endmodule

[rtl/att_cordic_pass.sv]
// One vectoring CORDIC pass: a registered quadrant pre-rotation followed by
// a chain of att_cordic_cell iterations. Depends on att_pkg and att_cordic_cell.
module att_cordic_pass (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              v_i,
  input  logic signed [att_pkg::VEC_W-1:0]  x_i,
  input  logic signed [att_pkg::VEC_W-1:0]  y_i,
  input  logic [att_pkg::SIDE_W-1:0]        side_i,
  output logic                              v_o,
  output att_pkg::vec_t                     q_o
);

  localparam int N = att_pkg::CORDIC_STAGES;

  logic          pre_v_r;
  att_pkg::vec_t pre_r;
  att_pkg::vec_t pre_nxt;
  logic          chain_v [N+1];
  att_pkg::vec_t chain_q [N+1];

  always_comb begin
    pre_nxt.zero = (x_i == '0) && (y_i == '0);
    pre_nxt.side = side_i;
    pre_nxt.x    = x_i;
    pre_nxt.y    = y_i;
    pre_nxt.ang  = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_nxt.x   = y_i;
        pre_nxt.y   = -x_i;
        pre_nxt.ang = att_pkg::DEG90_Q16;
      end else begin
        pre_nxt.x   = -y_i;
        pre_nxt.y   = x_i;
        pre_nxt.ang = -att_pkg::DEG90_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (en) begin
      pre_v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign chain_v[0] = pre_v_r;
  assign chain_q[0] = pre_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    att_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .shift_i (att_pkg::SHIFT_W'(i)),
      .atan_i  (att_pkg::atan_q16(i)),
      .v_i     (chain_v[i]),
      .d_i     (chain_q[i]),
      .v_o     (chain_v[i+1]),
      .q_o     (chain_q[i+1])
    );
  end

  always_comb begin
    q_o = chain_q[N];
    if (chain_q[N].zero) begin
      q_o.ang = '0;
    end
  end

  assign v_o = chain_v[N];

endmodule

[rtl/accel_tilt_angles.sv]
// Top level of the accelerometer tilt-angle block: two chained CORDIC passes,
// gain correction, conversion to hundredths of a degree and motion threshold.
// Depends on att_pkg and att_cordic_pass.
//
// Each transaction carries one x/y/z sample and yields one pitch, roll and
// motion flag, with one transaction accepted per clock cycle while in_stall
// is low. A transaction passes through the two chains of CORDIC cells plus
// the two pre-rotation, gain, conversion and output registers. in_stall is
// raised only while a result waits at the output and the stage before it
// is full. The motion threshold is written over the APB-style port at
// address 0.
module accel_tilt_angles (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_accel_x,
  input  logic signed [15:0]                  in_accel_y,
  input  logic signed [15:0]                  in_accel_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [att_pkg::PITCH_W-1:0]  out_pitch_angle,
  output logic signed [att_pkg::ROLL_W-1:0]   out_roll_angle,
  output logic                                out_motion_flag,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [att_pkg::ADDR_W-1:0]          paddr,
  input  logic [att_pkg::DATA_W-1:0]          pwdata,
  output logic [att_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int VW = att_pkg::VEC_W;
  localparam int AW = att_pkg::ANG_W;
  localparam int TW = att_pkg::THR_W;
  localparam int MW = AW + 7;

  function automatic logic [TW-1:0] hundredths(input logic signed [AW-1:0] a,
                                               input logic [TW-1:0] limit);
    logic [AW-1:0] m;
    logic [MW-1:0] p;
    logic [MW-17:0] h;
    m = (a < 0) ? AW'(-a) : AW'(a);
    p = MW'(m) * MW'(100) + MW'(32768);
    h = p[MW-1:16];
    return (h > (MW-16)'(limit)) ? limit : TW'(h);
  endfunction

  logic [TW-1:0] thr_r;
  logic          en;

  logic                    p1_v;
  att_pkg::vec_t           p1_q;
  logic signed [VW-1:0]    p1_x;
  logic signed [VW-1:0]    p1_y;

  logic signed [16:0]      negx;
  logic signed [34:0]      gain_prod;
  logic                    g_v_r;
  logic signed [VW-1:0]    g_x_r;
  logic signed [VW-1:0]    g_y_r;
  logic [att_pkg::SIDE_W-1:0] g_roll_r;

  logic                    p2_v;
  att_pkg::vec_t           p2_q;

  logic                    c_v_r;
  logic [TW-1:0]           c_pabs_r, c_pabs_nxt;
  logic [TW-1:0]           c_rabs_r, c_rabs_nxt;
  logic                    c_pneg_r, c_rneg_r;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [att_pkg::PITCH_W-1:0] out_pitch_r, out_pitch_nxt;
  logic signed [att_pkg::ROLL_W-1:0]  out_roll_r, out_roll_nxt;
  logic                               out_flag_r, out_flag_nxt;
  logic                               out_load;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= att_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == att_pkg::ADDR_MOTION_THRESHOLD) begin
      thr_r <= pwdata[TW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == att_pkg::ADDR_MOTION_THRESHOLD)
                  ? att_pkg::DATA_W'(thr_r) : '0;

  assign en       = !(out_valid_r && out_stall && c_v_r);
  assign in_stall = !en;

  assign p1_x = VW'($signed(in_accel_z[att_pkg::SAMPLE_W-1:0])) <<< att_pkg::FRAC_W;
  assign p1_y = VW'($signed(in_accel_y[att_pkg::SAMPLE_W-1:0])) <<< att_pkg::FRAC_W;

  att_cordic_pass u_roll_pass (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_valid),
    .x_i    (p1_x),
    .y_i    (p1_y),
    .side_i (att_pkg::SIDE_W'($signed(in_accel_x[att_pkg::SAMPLE_W-1:0]))),
    .v_o    (p1_v),
    .q_o    (p1_q)
  );

  // Gain correction of -x for the second pass.
  assign negx      = -$signed(p1_q.side[16:0]);
  assign gain_prod = 35'(negx) * 35'(att_pkg::GAIN_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_x_r    <= p1_q.x;
      g_y_r    <= VW'(gain_prod);
      g_roll_r <= att_pkg::SIDE_W'(p1_q.ang);
    end
  end

  att_cordic_pass u_pitch_pass (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (g_v_r),
    .x_i    (g_x_r),
    .y_i    (g_y_r),
    .side_i (g_roll_r),
    .v_o    (p2_v),
    .q_o    (p2_q)
  );

  // Conversion to hundredths of a degree.
  assign c_pabs_nxt = hundredths(p2_q.ang, att_pkg::PITCH_LIMIT);
  assign c_rabs_nxt = hundredths($signed(p2_q.side[AW-1:0]), att_pkg::ROLL_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pabs_r <= c_pabs_nxt;
      c_rabs_r <= c_rabs_nxt;
      c_pneg_r <= p2_q.ang < 0;
      c_rneg_r <= p2_q.side[AW-1];
    end
  end

  // Output register.
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pitch_nxt = out_pitch_r;
    out_roll_nxt  = out_roll_r;
    out_flag_nxt  = out_flag_r;
    if (out_load) begin
      out_valid_nxt = c_v_r;
      out_pitch_nxt = c_pneg_r ? -$signed(c_pabs_r) : $signed(c_pabs_r);
      out_roll_nxt  = c_rneg_r ? -$signed({1'b0, c_rabs_r}) : $signed({1'b0, c_rabs_r});
      out_flag_nxt  = (c_pabs_r >= thr_r) || (c_rabs_r >= thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pitch_r <= out_pitch_nxt;
    out_roll_r  <= out_roll_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_roll_angle  = out_roll_r;
  assign out_motion_flag = out_flag_r;

endmodule

[rtl/att_checker.sv]
// Port-level checks of accel_tilt_angles and the bind that attaches them.
// Depends on att_pkg for the output widths.
module att_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [att_pkg::PITCH_W-1:0]  out_pitch_angle,
  input logic signed [att_pkg::ROLL_W-1:0]   out_roll_angle,
  input logic                                out_motion_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_angle)
      && $stable(out_roll_angle) && $stable(out_motion_flag))
    else $error("Stalled output transaction changed.");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle >= -15'sd9000 && out_pitch_angle <= 15'sd9000)
    else $error("Pitch out of range.");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle >= -16'sd18000 && out_roll_angle <= 16'sd18000)
    else $error("Roll out of range.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output was free.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind accel_tilt_angles att_checker u_att_checker (.*);
